[rtl/sist_pkg.sv]
package sist_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Classification made by the front end, carried with each queued item.
  typedef struct packed {
    op_t  op;
    logic rev;   // start bound sorts after end bound
  } ctl_t;

  localparam int unsigned COUNT_OUT_W = 7;

  typedef struct packed {
    logic                   hit;
    logic [COUNT_OUT_W-1:0] count;
    logic                   status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PRE0,
    ST_PRE1,
    ST_MOVE,
    ST_POST,
    ST_RESP
  } state_t;

endpackage

[rtl/sist_front.sv]
module sist_front #(
  parameter int unsigned LINE_BITS   = 20,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned KW          = LINE_BITS + COLUMN_BITS + 1
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sist_pkg::op_t          in_operation,
  input  logic [LINE_BITS-1:0]   in_start_line,
  input  logic [COLUMN_BITS-1:0] in_start_column,
  input  logic                   in_start_open,
  input  logic [LINE_BITS-1:0]   in_end_line,
  input  logic [COLUMN_BITS-1:0] in_end_column,
  input  logic                   in_end_open,
  output logic                   push_valid,
  input  logic                   push_ready,
  output sist_pkg::ctl_t         push_ctl,
  output logic [KW-1:0]          push_lo,
  output logic [KW-1:0]          push_hi
);

  logic is_query;
  logic is_edit;

  // Bound key {line, column, closed}: an open bound sorts first at a position.
  assign is_query = (in_operation == sist_pkg::OP_QUERY);
  assign is_edit  = (in_operation == sist_pkg::OP_ADD) || (in_operation == sist_pkg::OP_DEL);

  assign push_lo = {in_start_line, in_start_column, is_query | ~in_start_open};
  assign push_hi = {in_end_line, in_end_column, ~in_end_open};

  assign push_ctl.op  = in_operation;
  assign push_ctl.rev = is_edit && (push_lo > push_hi);

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

[rtl/sist_queue.sv]
module sist_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   fill_r, fill_nxt;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt   = wp_r ^ do_push;
    rp_nxt   = rp_r ^ do_pop;
    fill_nxt = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

[rtl/sist_back.sv]
module sist_back #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned KW            = 37
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  sist_pkg::ctl_t q_ctl,
  input  logic [KW-1:0]  q_lo,
  input  logic [KW-1:0]  q_hi,
  output logic           res_valid,
  input  logic           res_ready,
  output sist_pkg::res_t res
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EW = 2 * KW;

  // Table storage: entry = {lo key, hi key}
  logic [EW-1:0] mem [MAX_INTERVALS];
  logic [EW-1:0] mem_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  logic [EW-1:0] wd;

  sist_pkg::state_t state_r, state_nxt;
  sist_pkg::ctl_t   ctl_r, ctl_nxt;
  logic [KW-1:0]    vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic [CW-1:0]    count_r, count_nxt, cnt_new_r, cnt_new_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    f_r, f_nxt, t_r, t_nxt;
  logic             cf_r, cf_nxt, ct_r, ct_nxt, fd_r, fd_nxt, td_r, td_nxt;
  logic [EW-1:0]    ef_r, ef_nxt, et_r, et_nxt;
  logic             pre0_en_r, pre0_en_nxt, pre1_en_r, pre1_en_nxt, post_en_r, post_en_nxt;
  logic [AW-1:0]    pre0_idx_r, pre0_idx_nxt, pre1_idx_r, pre1_idx_nxt;
  logic [AW-1:0]    post_idx_r, post_idx_nxt;
  logic [EW-1:0]    pre0_dat_r, pre0_dat_nxt, pre1_dat_r, pre1_dat_nxt;
  logic [EW-1:0]    post_dat_r, post_dat_nxt;
  logic             mv_up_r, mv_up_nxt;
  logic [CW-1:0]    mv_n_r, mv_n_nxt, mv_gap_r, mv_gap_nxt;
  logic [AW-1:0]    mv_src_r, mv_src_nxt, wdst_r, wdst_nxt;
  logic             hit_r, hit_nxt, status_r, status_nxt;
  logic             res_valid_r, res_valid_nxt;
  sist_pkg::res_t   res_r, res_nxt;

  logic [KW-1:0] e_lo, e_hi, ef_lo, ef_hi, et_lo, et_hi;
  logic [CW-1:0] j;
  logic          f_now, t_now, fd_now, td_now, scan_done;
  logic          full, cfp, ctp;
  logic [CW-1:0] tp, rm_a, rm_b, f_inc;
  logic          do_rm;

  assign e_lo  = mem_q[EW-1:KW];
  assign e_hi  = mem_q[KW-1:0];
  assign ef_lo = ef_r[EW-1:KW];
  assign ef_hi = ef_r[KW-1:0];
  assign et_lo = et_r[EW-1:KW];
  assign et_hi = et_r[KW-1:0];
  assign j     = k_r - CW'(1);
  assign full  = (count_r >= CW'(MAX_INTERVALS));
  assign f_inc = f_r + CW'(1);

  assign q_ready   = (state_r == sist_pkg::ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  always_comb begin
    we = 1'b0;
    wa = mv_src_r;
    wd = mem_q;
    ra = k_r[AW-1:0];
    unique case (state_r)
      sist_pkg::ST_PRE0: begin
        we = pre0_en_r;
        wa = pre0_idx_r;
        wd = pre0_dat_r;
      end
      sist_pkg::ST_PRE1: begin
        we = pre1_en_r;
        wa = pre1_idx_r;
        wd = pre1_dat_r;
      end
      sist_pkg::ST_MOVE: begin
        we = pend_r;
        wa = wdst_r;
        ra = mv_src_r;
      end
      sist_pkg::ST_POST: begin
        we = post_en_r;
        wa = post_idx_r;
        wd = post_dat_r;
      end
      default: begin
      end
    endcase
  end

  // Per-entry locate tests for both bounds of the item.
  assign f_now  = pend_r && !fd_r && ((e_lo > vlo_r) || !(e_hi < vlo_r));
  assign t_now  = pend_r && !td_r && ((e_lo > vhi_r) || !(e_hi < vhi_r));
  assign fd_now = fd_r || f_now;
  assign td_now = td_r || t_now;
  assign scan_done = fd_now && (td_now || (ctl_r.op == sist_pkg::OP_QUERY));

  // Delete trimming decisions.
  assign cfp = cf_r && (vlo_r > ef_lo);
  assign ctp = ct_r && (vhi_r < et_hi);
  assign tp  = (ct_r && !ctp) ? t_r + CW'(1) : t_r;

  always_comb begin
    state_nxt = state_r;
    ctl_nxt = ctl_r; vlo_nxt = vlo_r; vhi_nxt = vhi_r;
    count_nxt = count_r; cnt_new_nxt = cnt_new_r;
    k_nxt = k_r; pend_nxt = pend_r;
    f_nxt = f_r; t_nxt = t_r; cf_nxt = cf_r; ct_nxt = ct_r; fd_nxt = fd_r; td_nxt = td_r;
    ef_nxt = ef_r; et_nxt = et_r;
    pre0_en_nxt = pre0_en_r; pre0_idx_nxt = pre0_idx_r; pre0_dat_nxt = pre0_dat_r;
    pre1_en_nxt = pre1_en_r; pre1_idx_nxt = pre1_idx_r; pre1_dat_nxt = pre1_dat_r;
    post_en_nxt = post_en_r; post_idx_nxt = post_idx_r; post_dat_nxt = post_dat_r;
    mv_up_nxt = mv_up_r; mv_n_nxt = mv_n_r; mv_gap_nxt = mv_gap_r;
    mv_src_nxt = mv_src_r; wdst_nxt = wdst_r;
    hit_nxt = hit_r; status_nxt = status_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt = res_r;
    rm_a = f_inc;
    rm_b = t_r;
    do_rm = 1'b0;

    unique case (state_r)
      sist_pkg::ST_IDLE: begin
        if (q_valid) begin
          ctl_nxt = q_ctl;
          vlo_nxt = q_lo;
          vhi_nxt = q_hi;
          k_nxt = '0; pend_nxt = 1'b0; fd_nxt = 1'b0; td_nxt = 1'b0;
          cf_nxt = 1'b0; ct_nxt = 1'b0;
          pre0_en_nxt = 1'b0; pre1_en_nxt = 1'b0; post_en_nxt = 1'b0;
          mv_n_nxt = '0;
          hit_nxt = 1'b0; status_nxt = 1'b0;
          cnt_new_nxt = count_r;
          if (q_ctl.op == sist_pkg::OP_CLEAR) begin
            cnt_new_nxt = '0;
            state_nxt = sist_pkg::ST_RESP;
          end else if (q_ctl.rev) begin
            state_nxt = sist_pkg::ST_RESP;
          end else begin
            state_nxt = sist_pkg::ST_SCAN;
          end
        end
      end

      sist_pkg::ST_SCAN: begin
        if (f_now) begin
          f_nxt = j;
          cf_nxt = !(e_lo > vlo_r);
          ef_nxt = mem_q;
        end
        if (t_now) begin
          t_nxt = j;
          ct_nxt = !(e_lo > vhi_r);
          et_nxt = mem_q;
        end
        fd_nxt = fd_now;
        td_nxt = td_now;
        if (scan_done) begin
          pend_nxt = 1'b0;
          state_nxt = sist_pkg::ST_DECIDE;
        end else if (k_r == count_r) begin
          // Walked off the end: unresolved bounds locate past the last entry.
          if (!fd_now) begin
            f_nxt = count_r;
            cf_nxt = 1'b0;
          end
          if (!td_now) begin
            t_nxt = count_r;
            ct_nxt = 1'b0;
          end
          pend_nxt = 1'b0;
          state_nxt = sist_pkg::ST_DECIDE;
        end else begin
          k_nxt = k_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end

      sist_pkg::ST_DECIDE: begin
        state_nxt = sist_pkg::ST_PRE0;
        pend_nxt = 1'b0;
        priority case (ctl_r.op)
          sist_pkg::OP_QUERY: begin
            hit_nxt = cf_r;
          end
          sist_pkg::OP_ADD: begin
            if (!cf_r && !ct_r && (f_r == t_r)) begin
              if (full) begin
                status_nxt = 1'b1;
              end else begin
                mv_up_nxt = 1'b1;
                mv_n_nxt = count_r - f_r;
                mv_src_nxt = AW'(count_r - CW'(1));
                post_en_nxt = 1'b1;
                post_idx_nxt = f_r[AW-1:0];
                post_dat_nxt = {vlo_r, vhi_r};
                cnt_new_nxt = count_r + CW'(1);
              end
            end else begin
              // Merge into one entry at the first touched slot, drop the rest.
              pre0_en_nxt = 1'b1;
              pre0_idx_nxt = f_r[AW-1:0];
              pre0_dat_nxt = {cf_r ? ef_lo : vlo_r, ct_r ? et_hi : vhi_r};
              rm_a = f_inc;
              rm_b = ct_r ? t_r + CW'(1) : t_r;
              do_rm = 1'b1;
            end
          end
          default: begin
            if (!((f_r == t_r) && !cf_r && !ct_r)) begin
              if (cfp && ctp && (f_r == tp)) begin
                // Split one entry in two.
                if (full) begin
                  status_nxt = 1'b1;
                end else begin
                  pre0_en_nxt = 1'b1;
                  pre0_idx_nxt = f_r[AW-1:0];
                  pre0_dat_nxt = {ef_lo, vlo_r ^ KW'(1)};
                  mv_up_nxt = 1'b1;
                  mv_n_nxt = count_r - f_inc;
                  mv_src_nxt = AW'(count_r - CW'(1));
                  post_en_nxt = 1'b1;
                  post_idx_nxt = f_inc[AW-1:0];
                  post_dat_nxt = {vhi_r ^ KW'(1), ef_hi};
                  cnt_new_nxt = count_r + CW'(1);
                end
              end else begin
                pre0_en_nxt = cfp;
                pre0_idx_nxt = f_r[AW-1:0];
                pre0_dat_nxt = {ef_lo, vlo_r ^ KW'(1)};
                pre1_en_nxt = ctp;
                pre1_idx_nxt = t_r[AW-1:0];
                pre1_dat_nxt = {vhi_r ^ KW'(1), et_hi};
                rm_a = cfp ? f_inc : f_r;
                rm_b = tp;
                do_rm = 1'b1;
              end
            end
          end
        endcase
        if (do_rm && (rm_b > rm_a)) begin
          mv_up_nxt = 1'b0;
          mv_gap_nxt = rm_b - rm_a;
          mv_n_nxt = count_r - rm_b;
          mv_src_nxt = rm_b[AW-1:0];
          cnt_new_nxt = count_r - (rm_b - rm_a);
        end
      end

      sist_pkg::ST_PRE0: begin
        state_nxt = sist_pkg::ST_PRE1;
      end

      sist_pkg::ST_PRE1: begin
        state_nxt = sist_pkg::ST_MOVE;
      end

      sist_pkg::ST_MOVE: begin
        if (mv_n_r != '0) begin
          wdst_nxt = mv_up_r ? mv_src_r + AW'(1) : mv_src_r - mv_gap_r[AW-1:0];
          mv_src_nxt = mv_up_r ? mv_src_r - AW'(1) : mv_src_r + AW'(1);
          mv_n_nxt = mv_n_r - CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = sist_pkg::ST_POST;
          end
        end
      end

      sist_pkg::ST_POST: begin
        state_nxt = sist_pkg::ST_RESP;
      end

      sist_pkg::ST_RESP: begin
        if (!res_valid_r || res_ready) begin
          res_valid_nxt = 1'b1;
          res_nxt.hit = hit_r;
          res_nxt.count = sist_pkg::COUNT_OUT_W'(cnt_new_r);
          res_nxt.status = status_r;
          count_nxt = cnt_new_r;
          state_nxt = sist_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sist_pkg::ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt; vlo_r <= vlo_nxt; vhi_r <= vhi_nxt;
    cnt_new_r <= cnt_new_nxt; k_r <= k_nxt;
    f_r <= f_nxt; t_r <= t_nxt; cf_r <= cf_nxt; ct_r <= ct_nxt;
    fd_r <= fd_nxt; td_r <= td_nxt; ef_r <= ef_nxt; et_r <= et_nxt;
    pre0_en_r <= pre0_en_nxt; pre0_idx_r <= pre0_idx_nxt; pre0_dat_r <= pre0_dat_nxt;
    pre1_en_r <= pre1_en_nxt; pre1_idx_r <= pre1_idx_nxt; pre1_dat_r <= pre1_dat_nxt;
    post_en_r <= post_en_nxt; post_idx_r <= post_idx_nxt; post_dat_r <= post_dat_nxt;
    mv_up_r <= mv_up_nxt; mv_n_r <= mv_n_nxt; mv_gap_r <= mv_gap_nxt;
    mv_src_r <= mv_src_nxt; wdst_r <= wdst_nxt;
    hit_r <= hit_nxt; status_r <= status_nxt;
    res_r <= res_nxt;
  end

endmodule

[rtl/sorted_interval_set_table.sv]
// Sorted interval set table. Holds up to MAX_INTERVALS sorted, disjoint
// intervals over (line, column) with open/closed bounds; each transaction adds,
// deletes, queries or clears and returns one result (hit, entry count, full
// status). Operations run one at a time in a back end that walks the table
// memory one entry per cycle: a locate pass, then a shift pass over the
// entries it moves (at most count of them); a query moves no entries and a
// clear goes straight to its result. A two-entry queue behind the input lets up
// to two more transactions be taken while one is at work, and a result register
// lets the next one start while a result waits. Table contents need no clearing
// pass: only entries below the count are ever used.
module sorted_interval_set_table #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned LINE_BITS     = 20,
  parameter int unsigned COLUMN_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic [LINE_BITS-1:0]   in_start_line,
  input  logic [COLUMN_BITS-1:0] in_start_column,
  input  logic                   in_start_open,
  input  logic [LINE_BITS-1:0]   in_end_line,
  input  logic [COLUMN_BITS-1:0] in_end_column,
  input  logic                   in_end_open,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_hit,
  output logic [6:0]             out_entry_count,
  output logic                   out_status
);

  localparam int unsigned KW = LINE_BITS + COLUMN_BITS + 1;
  localparam int unsigned CTW = $bits(sist_pkg::ctl_t);
  localparam int unsigned QW = CTW + 2 * KW;

  // Front end: classify and build sortable bound keys.
  logic           push_valid, push_ready;
  sist_pkg::ctl_t push_ctl;
  logic [KW-1:0]  push_lo, push_hi;

  // Queue output toward the back end.
  logic           pop_valid, pop_ready;
  logic [QW-1:0]  pop_data;
  sist_pkg::ctl_t pop_ctl;
  sist_pkg::res_t res;

  sist_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .KW          (KW)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (sist_pkg::op_t'(in_operation)),
    .in_start_line   (in_start_line),
    .in_start_column (in_start_column),
    .in_start_open   (in_start_open),
    .in_end_line     (in_end_line),
    .in_end_column   (in_end_column),
    .in_end_open     (in_end_open),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_ctl        (push_ctl),
    .push_lo         (push_lo),
    .push_hi         (push_hi)
  );

  // Hold classified transactions so intake runs ahead of execution.
  sist_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_lo, push_hi}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_ctl = sist_pkg::ctl_t'(pop_data[QW-1:2*KW]);

  // Back end: locate, rewrite and shift entries in the table memory.
  sist_back #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .KW            (KW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_ctl     (pop_ctl),
    .q_lo      (pop_data[2*KW-1:KW]),
    .q_hi      (pop_data[KW-1:0]),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_hit         = res.hit;
  assign out_entry_count = res.count;
  assign out_status      = res.status;

endmodule

[rtl/sist_checker.sv]
module sist_checker #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic [6:0] out_entry_count,
  input logic       out_status
);

  // A refusal only comes from add or delete, a hit only from query.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_status))
    else $error("hit and refusal in one result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((MAX_INTERVALS > 127) || (out_entry_count <= 7'(MAX_INTERVALS))))
    else $error("entry count above table size");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_count) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind sorted_interval_set_table sist_checker #(
  .MAX_INTERVALS (MAX_INTERVALS)
) u_sist_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);
